>>> rtl/gwa_pkg.sv
// ----------------------------------------------------------------------------
// gwa_pkg
// shared types and codes for the grouped weighted allocation block
// ----------------------------------------------------------------------------
package gwa_pkg;

   localparam logic [1:0] MODE_ACCUM = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam int POP_W   = 32;
   localparam int WGT_W   = 32;
   localparam int COUNT_W = 17;
   localparam int SUM_W   = 48;
   localparam int PROD_W  = 64;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic [POP_W-1:0]   first_pop;
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   vol_sum;
      logic [SUM_W-1:0]   area_tot;
   } entry_type;

endpackage

>>> rtl/grouped_weighted_allocation_top.sv
// ----------------------------------------------------------------------------
// grouped_weighted_allocation_top
// splits a group population over its cells in proportion to volume or area
// ----------------------------------------------------------------------------
// One item is worked at a time. The per-group table lives in a single
// synchronous memory (one entry per group: first population, cell count,
// volume sum, area sum) with a registered read. An accumulate beat is
// accepted with a table read, then written back. An allocate beat is
// accepted with a table read, then weight select, one 32x32 multiply, then a
// restoring divider that retires one quotient bit per cycle over 64 bits,
// then the result register. Clear beats, and reset, start a sweep that
// zeroes the memory one entry per cycle, during which req_tready is low. A
// result waits in the output register while the next beat is accepted.
// Group 0 or a group above MAX_GROUPS is ignored on accumulate and gives
// share_valid 0 on allocate.

module grouped_weighted_allocation_top #(
   parameter int MAX_GROUPS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tuser: mode[1:0]
   input  logic [1:0]                      req_tuser,
   // req_tdata: group_id[10:0], pop_missing[11], pop_value[43:12],
   // volume_missing[44], volume_value[76:45], area_missing[77],
   // area_value[109:78], zero fill[111:110]
   input  logic [gwa_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rsp_tuser: share_valid[0]
   output logic                            rsp_tuser,
   // rsp_tdata: share_value[31:0]
   output logic [gwa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);
   import gwa_pkg::*;

   localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_GROUPS - 1);

   // sequencer codes
   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_CALC = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // unpacked request fields
   logic [10:0]       f_group;
   logic              f_pop_miss;
   logic [POP_W-1:0]  f_pop;
   logic              f_vol_miss;
   logic [WGT_W-1:0]  f_vol;
   logic              f_area_miss;
   logic [WGT_W-1:0]  f_area;

   assign f_group     = req_tdata[10:0];
   assign f_pop_miss  = req_tdata[11];
   assign f_pop       = req_tdata[43:12];
   assign f_vol_miss  = req_tdata[44];
   assign f_vol       = req_tdata[76:45];
   assign f_area_miss = req_tdata[77];
   assign f_area      = req_tdata[109:78];

   logic [2:0] state_ff, state_in;
   logic       accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // group check and table index
   logic          grp_ok;
   logic [31:0]   grp_wide;
   logic [IW-1:0] grp_idx;
   assign grp_wide = {21'd0, f_group};
   assign grp_ok   = (f_group != 11'd0) && (grp_wide <= 32'(MAX_GROUPS));
   assign grp_idx  = IW'(grp_wide - 32'd1);

   // positive weights, missing or non-positive is zero
   logic [WGT_W-1:0] vol_w, area_w;
   assign vol_w  = (f_vol_miss || f_vol[WGT_W-1]) ? '0 : f_vol;
   assign area_w = (f_area_miss || f_area[WGT_W-1]) ? '0 : f_area;

   // captured beat
   logic [1:0]       mode_ff;
   logic             ok_ff;
   logic             pop_miss_ff;
   logic [POP_W-1:0] pop_ff;
   logic [WGT_W-1:0] vol_w_ff, area_w_ff;
   logic [IW-1:0]    idx_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= req_tuser;
         ok_ff       <= grp_ok;
         pop_miss_ff <= f_pop_miss;
         pop_ff      <= f_pop;
         vol_w_ff    <= vol_w;
         area_w_ff   <= area_w;
         idx_ff      <= grp_idx;
      end
   end

   // table memory
   entry_type     mem [MAX_GROUPS];
   entry_type     rd_ff;
   logic          mem_we;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[grp_idx];
   end

   // clear sweep index
   logic [IW-1:0] clr_idx_ff, clr_idx_in;

   // accumulate update
   logic [SUM_W:0]     vol_add, area_add;
   entry_type          acc_entry;
   assign vol_add  = {1'b0, rd_ff.vol_sum} + (SUM_W+1)'(vol_w_ff);
   assign area_add = {1'b0, rd_ff.area_tot} + (SUM_W+1)'(area_w_ff);

   always_comb begin
      acc_entry           = rd_ff;
      if (rd_ff.count == '0) begin
         acc_entry.first_pop = pop_ff;
      end
      if (rd_ff.count != '1) begin
         acc_entry.count = rd_ff.count + COUNT_W'(1);
      end
      acc_entry.vol_sum  = vol_add[SUM_W] ? '1 : vol_add[SUM_W-1:0];
      acc_entry.area_tot = area_add[SUM_W] ? '1 : area_add[SUM_W-1:0];
   end

   // allocate operands
   logic              alloc_ok;
   logic [WGT_W-1:0]  mul_b;
   logic [SUM_W-1:0]  den_sel;
   assign alloc_ok = ok_ff && (rd_ff.count != '0);

   always_comb begin
      priority if (rd_ff.vol_sum != '0) begin
         mul_b   = vol_w_ff;
         den_sel = rd_ff.vol_sum;
      end else if (rd_ff.area_tot != '0) begin
         mul_b   = area_w_ff;
         den_sel = rd_ff.area_tot;
      end else begin
         // fall back to an even split over the cell count
         mul_b   = WGT_W'(1);
         den_sel = SUM_W'(rd_ff.count);
      end
   end

   logic [POP_W-1:0]  mul_a_ff, mul_a_in;
   logic [WGT_W-1:0]  mul_b_ff, mul_b_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [5:0]        step_ff, step_in;
   logic              valid_ff, valid_in;

   // one restoring divide step
   logic [SUM_W:0] rem_sh, rem_sub;
   logic           q_bit;
   assign rem_sh  = {rem_ff, quo_ff[PROD_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign q_bit   = (rem_sh >= {1'b0, den_ff});

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      mem_we       = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = acc_entry;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_CLR: begin
            mem_we     = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = '0;
            clr_idx_in = clr_idx_ff + IW'(1);
            if (clr_idx_ff == LAST_IDX) begin
               clr_idx_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               priority if (req_tuser == MODE_CLEAR) begin
                  state_in = S_CLR;
               end else if (req_tuser == MODE_ACCUM || req_tuser == MODE_ALLOC) begin
                  state_in = S_CALC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CALC: begin
            if (mode_ff == MODE_ACCUM) begin
               mem_we   = ok_ff && !pop_miss_ff;
               state_in = S_IDLE;
            end else begin
               valid_in = alloc_ok;
               mul_a_in = rd_ff.first_pop;
               mul_b_in = mul_b;
               den_in   = den_sel;
               state_in = alloc_ok ? S_MUL : S_OUT;
            end
         end
         S_MUL: begin
            // numerator with half the divisor added for round half up
            quo_in   = PROD_W'(mul_a_ff) * PROD_W'(mul_b_ff) + PROD_W'(den_ff >> 1);
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = q_bit ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            quo_in  = {quo_ff[PROD_W-2:0], q_bit};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = valid_ff;
               if (!valid_ff) begin
                  rsp_data_in = '0;
               end else if (quo_ff[PROD_W-1:RSP_DATA_W] != '0) begin
                  rsp_data_in = '1;
               end else begin
                  rsp_data_in = quo_ff[RSP_DATA_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      valid_ff    <= valid_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/grouped_weighted_allocation_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_weighted_allocation_top_test
// checks per-group population shares against an in-bench prediction
// ----------------------------------------------------------------------------
// Beats are driven on the request stream with random gaps. Accumulate
// and clear beats update a local copy of the group tables, and each
// allocate beat leaves one expected share in a queue. The response stream is
// stalled at random and every beat is compared with the oldest expectation.

module grouped_weighted_allocation_top_test;
   import gwa_pkg::*;

   localparam int GROUPS     = 1024;
   localparam int RAND_BEATS = 1430;
   localparam logic [16:0] COUNT_TOP = 17'h1FFFF;
   localparam logic [47:0] SUM_TOP   = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic        ok;
      logic [31:0] share;
   } share_type;

   // a request beat, unpacked
   typedef struct {
      logic [1:0]  mode;
      logic [10:0] grp;
      logic        pop_miss;
      logic [31:0] pop;
      logic        vol_miss;
      logic [31:0] vol;
      logic        area_miss;
      logic [31:0] area;
   } cell_type;

   // ---------------------------------------------------------------------
   // scoreboard: group tables and pending shares
   // ---------------------------------------------------------------------
   class share_board;
      logic [31:0] first_pop [GROUPS];
      logic        seen      [GROUPS];
      logic [16:0] count     [GROUPS];
      logic [47:0] vol_sum   [GROUPS];
      logic [47:0] area_tot  [GROUPS];
      share_type   pending[$];
      int          errors;

      function new();
         errors = 0;
         foreach (first_pop[i]) first_pop[i] = '0;
         wipe();
      endfunction

      function void wipe();
         foreach (seen[i]) begin
            seen[i] = 1'b0;
            count[i] = '0;
            vol_sum[i] = '0;
            area_tot[i] = '0;
         end
      endfunction

      function logic [31:0] weight(logic miss, logic [31:0] v);
         return (miss || v[31]) ? 32'd0 : v;
      endfunction

      function logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
         logic [48:0] s;
         s = {1'b0, a} + 49'(b);
         return s[48] ? SUM_TOP : s[47:0];
      endfunction

      function logic [31:0] div_round(logic [63:0] num, logic [63:0] den);
         logic [64:0] q;
         q = ({1'b0, num} + 65'(den >> 1)) / 65'(den);
         return (q > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      endfunction

      // note an accepted request beat
      function void note_cell(cell_type c);
         int idx;
         logic g_ok;
         logic [31:0] vw, aw, w;
         logic [63:0] den;
         share_type r;
         g_ok = c.grp >= 1 && c.grp <= GROUPS;
         idx = g_ok ? c.grp - 1 : 0;
         vw = weight(c.vol_miss, c.vol);
         aw = weight(c.area_miss, c.area);
         case (c.mode)
            MODE_CLEAR: wipe();
            MODE_ACCUM: begin
               if (g_ok && !c.pop_miss) begin
                  if (!seen[idx]) begin
                     first_pop[idx] = c.pop;
                     seen[idx] = 1'b1;
                  end
                  if (count[idx] != COUNT_TOP) count[idx]++;
                  vol_sum[idx] = add_sat(vol_sum[idx], vw);
                  area_tot[idx] = add_sat(area_tot[idx], aw);
               end
            end
            MODE_ALLOC: begin
               r = '0;
               if (g_ok && seen[idx] && count[idx] != 0) begin
                  r.ok = 1'b1;
                  den = 64'(vol_sum[idx]);
                  w = vw;
                  if (den == 0) begin
                     den = 64'(area_tot[idx]);
                     w = aw;
                  end
                  if (den == 0)
                     r.share = div_round(64'(first_pop[idx]), 64'(count[idx]));
                  else r.share = div_round(64'(first_pop[idx]) * 64'(w), den);
               end
               pending.push_back(r);
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // check an accepted response beat
      task check_share(logic ok, logic [31:0] share);
         share_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected share ok=%0b value=%h", ok, share));
            return;
         end
         e = pending.pop_front();
         if (ok !== e.ok)
            report($sformatf("share_valid got %b want %b", ok, e.ok));
         if (share !== e.share)
            report($sformatf("share_value got %h want %h", share, e.share));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic [1:0] req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 0;

   share_board board = new();
   bit stim_done = 0;
   int hot_grp;

   always #6 clock = ~clock;

   grouped_weighted_allocation_top #(.MAX_GROUPS(GROUPS)) dut (
      .clock(clock), .reset(reset),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
   );

   // idle before a beat: often none, else a random idle gap with valid low
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (n != 0) req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // drive one request beat and hold until it is taken
   task automatic send_cell(cell_type c);
      idle_gap();
      req_tuser <= c.mode;
      req_tdata <= {2'b00, c.area, c.area_miss, c.vol, c.vol_miss,
                    c.pop, c.pop_miss, c.grp};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_cell(c);
      @(negedge clock);
   endtask

   function automatic cell_type make_cell(logic [1:0] m, logic [10:0] g);
      cell_type c;
      c.mode = m;
      c.grp = g;
      c.pop_miss = ($urandom_range(0, 9) == 0);
      c.pop = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 20);
      c.vol_miss = ($urandom_range(0, 9) == 0);
      c.vol = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 1 << 22);
      c.area_miss = ($urandom_range(0, 9) == 0);
      c.area = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 1 << 22);
      return c;
   endfunction

   // response side: random wait before each beat, sample at rising edge
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (n != 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_share(rsp_tuser, rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin
      cell_type c;
      logic [10:0] g;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: edge groups, missing fields, fallbacks, saturation
      c = make_cell(MODE_ALLOC, 11'd5); send_cell(c);      // empty group
      c = make_cell(MODE_ALLOC, 11'd0); send_cell(c);      // group zero
      c = make_cell(MODE_ALLOC, 11'd1025); send_cell(c);   // group too big
      c = make_cell(MODE_ALLOC, 11'h7FF); send_cell(c);
      c = '{MODE_ACCUM, 11'd1, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h7FFF_FFFF,
            1'b0, 32'h7FFF_FFFF};
      send_cell(c);
      c = '{MODE_ACCUM, 11'd1, 1'b0, 32'd5, 1'b0, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF};
      send_cell(c);
      c = '{MODE_ALLOC, 11'd1, 1'b1, 32'h0, 1'b0, 32'h7FFF_FFFF, 1'b0, 32'd1};
      send_cell(c);
      c = '{MODE_ALLOC, 11'd1, 1'b0, 32'h0, 1'b1, 32'h8000_0000, 1'b0, 32'd1};
      send_cell(c);
      // area fallback: negative volume, missing population
      c = '{MODE_ACCUM, 11'd1024, 1'b0, 32'd1000, 1'b0, 32'h8000_0000, 1'b0, 32'd3};
      send_cell(c);
      c = '{MODE_ACCUM, 11'd1024, 1'b1, 32'd7, 1'b0, 32'd9, 1'b0, 32'd9};
      send_cell(c);
      c = '{MODE_ALLOC, 11'd1024, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 32'd1};
      send_cell(c);
      c = '{MODE_ALLOC, 11'd1024, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 32'h7FFF_FFFF};
      send_cell(c);
      // count fallback: no weights at all
      c = '{MODE_ACCUM, 11'd2, 1'b0, 32'd1001, 1'b1, 32'd0, 1'b0, 32'd0};
      send_cell(c);
      c = '{MODE_ACCUM, 11'd2, 1'b0, 32'd1, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'd4};
      send_cell(c);
      c = '{MODE_ACCUM, 11'd0, 1'b0, 32'd1, 1'b0, 32'd4, 1'b0, 32'd4};
      send_cell(c);
      c = '{MODE_ALLOC, 11'd2, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0};
      send_cell(c);
      c = make_cell(2'd3, 11'd2); send_cell(c);             // unused mode
      c = make_cell(MODE_CLEAR, 11'd0); send_cell(c);
      c = make_cell(MODE_ALLOC, 11'd1); send_cell(c);       // cleared group
      c = make_cell(MODE_ALLOC, 11'd2); send_cell(c);

      // random: accumulate and allocate beats mixed, some clears, mostly on few groups
      for (int i = 0; i < RAND_BEATS; i++) begin
         hot_grp = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
                                             : $urandom_range(1, 12);
         g = 11'(hot_grp);
         case ($urandom_range(0, 99)) inside
            [0:44]:  c = make_cell(MODE_ACCUM, g);
            [45:94]: c = make_cell(MODE_ALLOC, g);
            [95:97]: c = make_cell(MODE_CLEAR, g);
            default: c = make_cell(2'd3, g);
         endcase
         send_cell(c);
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // slowest run: ~1450 beats, each with an allocate, a full clear sweep, an idle gap and a stall
   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
